@@ rtl/log_level_keyword_scanner_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Log level keyword scanner: assertion macros
// Short concurrent checks used by the scanner's back end.
// ---------------------------------------------------------------------------
`ifndef LOG_LEVEL_KEYWORD_SCANNER_UNIT_MACROS_SVH
`define LOG_LEVEL_KEYWORD_SCANNER_UNIT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define LLKS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define LLKS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define LLKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/llks_pkg.sv @@
// ---------------------------------------------------------------------------
// Log level keyword scanner: package
// Types, keyword trie tables and character class functions.
// ---------------------------------------------------------------------------
package llks_pkg;

  localparam int CHAR_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int START_W    = 16;
  localparam int LEVEL_W    = 3;
  localparam int LETTER_W   = 5;
  localparam int NODE_COUNT = 40;
  localparam int NODE_W     = 6;

  localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RST = 16'd256;

  // Severity codes reported on the result channel
  typedef enum logic [LEVEL_W-1:0] {
    LVL_NONE  = 3'd0,
    LVL_TRACE = 3'd1,
    LVL_DEBUG = 3'd2,
    LVL_INFO  = 3'd3,
    LVL_WARN  = 3'd4,
    LVL_ERROR = 3'd5,
    LVL_FATAL = 3'd6
  } level_t;

  // One classified code unit as it travels from front to back
  typedef struct packed {
    logic                letter;
    logic                bnd;
    logic [LETTER_W-1:0] idx;
    logic                last;
  } beat_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic  valid;
    beat_t beat;
  } qstat_t;

  // Trie: parent of each node, letter (A = 0) on the edge into it, and level
  localparam logic [NODE_W-1:0] NODE_PARENT [NODE_COUNT] = '{
    6'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd0, 6'd6, 6'd7, 6'd8,
    6'd9, 6'd0, 6'd11, 6'd12, 6'd13, 6'd0, 6'd15, 6'd16, 6'd17, 6'd18,
    6'd19, 6'd20, 6'd0, 6'd22, 6'd23, 6'd24, 6'd25, 6'd0, 6'd27, 6'd28,
    6'd29, 6'd30, 6'd0, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38
  };

  localparam logic [LETTER_W-1:0] NODE_LETTER [NODE_COUNT] = '{
    5'd0, 5'd19, 5'd17, 5'd0, 5'd2, 5'd4, 5'd3, 5'd4, 5'd1, 5'd20,
    5'd6, 5'd8, 5'd13, 5'd5, 5'd14, 5'd22, 5'd0, 5'd17, 5'd13, 5'd8,
    5'd13, 5'd6, 5'd4, 5'd17, 5'd17, 5'd14, 5'd17, 5'd5, 5'd0, 5'd19,
    5'd0, 5'd11, 5'd2, 5'd17, 5'd8, 5'd19, 5'd8, 5'd2, 5'd0, 5'd11
  };

  localparam level_t NODE_LEVEL [NODE_COUNT] = '{
    LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_TRACE,
    LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_DEBUG,
    LVL_NONE, LVL_NONE, LVL_NONE, LVL_INFO,
    LVL_NONE, LVL_NONE, LVL_NONE, LVL_WARN, LVL_NONE, LVL_NONE, LVL_WARN,
    LVL_NONE, LVL_NONE, LVL_ERROR, LVL_NONE, LVL_ERROR,
    LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_FATAL,
    LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE, LVL_NONE,
    LVL_FATAL
  };

  // Child of a node along a letter, zero when there is none
  function automatic logic [NODE_W-1:0] trie_child(input logic [NODE_W-1:0] node,
                                                   input logic [LETTER_W-1:0] idx);
    logic [NODE_W-1:0] nx;
    nx = '0;
    for (int k = 1; k < NODE_COUNT; k++) begin
      if (NODE_PARENT[k] == node && NODE_LETTER[k] == idx) begin
        nx = NODE_W'(k);
      end
    end
    return nx;
  endfunction

  function automatic logic is_white(input logic [CHAR_W-1:0] c);
    return c inside {[16'd9:16'd13], 16'd32, 16'h0085, 16'h00A0, 16'h1680,
                     [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F,
                     16'h205F, 16'h3000};
  endfunction

  function automatic logic is_boundary(input logic [CHAR_W-1:0] c);
    return (c == 16'd0) || is_white(c) ||
           (c inside {16'h005B, 16'h005D, 16'h0028, 16'h0029, 16'h007B, 16'h007D,
                      16'h003C, 16'h003E, 16'h003A, 16'h003D, 16'h002C, 16'h007C,
                      16'h002D, 16'h002F});
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c inside {[16'h0041:16'h005A], [16'h0061:16'h007A]});
  endfunction

endpackage

@@ rtl/log_level_keyword_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// Log level keyword scanner unit
// Spots the earliest bounded severity keyword in a UTF-16 log line.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_char_code and in_last_in_line with push; a unit
//   is taken at each edge where push is high and full is low. Mark the last
//   unit of every line with in_last_in_line.
//   Result channel: one beat per line. While empty is low, out_level_code
//   and out_match_start show the oldest verdict; pop takes it.
//   Configuration: cfg_wr_en with cfg_wr_data sets scan_limit (reset 256);
//   write it only between lines with the block drained.
// Throughput and result path:
//   One unit per cycle sustained while the back end does not stall. A line's
//   verdict reaches the result ports through two registers: the beat queue
//   registers its last unit when it is taken, and the trie step then loads
//   the result register as it takes that unit from the head of the queue.
// Reset:
//   Synchronous, active low. Queue and result slot empty, line state cleared,
//   scan_limit back to 256.
// Stalls:
//   A held verdict stops the trie back end only at the next line end; that
//   unit waits at the head of the beat queue, and full rises once one more
//   unit is queued behind it.
// ---------------------------------------------------------------------------
module log_level_keyword_scanner_unit #(
  parameter int POS_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [llks_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                         push,
  output logic                         full,
  input  logic [llks_pkg::CHAR_W-1:0]  in_char_code,
  input  logic                         in_last_in_line,
  output logic                         empty,
  input  logic                         pop,
  output logic [llks_pkg::LEVEL_W-1:0] out_level_code,
  output logic [llks_pkg::START_W-1:0] out_match_start
);
  import llks_pkg::*;

  logic [LIMIT_W-1:0] scan_limit_r;
  logic [LIMIT_W-1:0] scan_limit_nxt;
  beat_t              in_beat;
  qstat_t             q_stat;
  logic               q_pop;
  logic               q_push;

  // Hold the scan limit register
  assign scan_limit_nxt = cfg_wr_en ? cfg_wr_data : scan_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RST;
    end else begin
      scan_limit_r <= scan_limit_nxt;
    end
  end

  assign q_push = push && !full;

  llks_front u_front (
    .char_code    (in_char_code),
    .last_in_line (in_last_in_line),
    .beat         (in_beat)
  );

  llks_beat_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_beat (in_beat),
    .full    (full),
    .rd_en   (q_pop),
    .rd_stat (q_stat)
  );

  llks_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_limit  (scan_limit_r),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .level_code  (out_level_code),
    .match_start (out_match_start)
  );

endmodule

@@ rtl/llks_front.sv @@
// ---------------------------------------------------------------------------
// Log level keyword scanner: front end
// Classifies each incoming code unit into letter, boundary and letter index.
// ---------------------------------------------------------------------------
module llks_front (
  input  logic [llks_pkg::CHAR_W-1:0] char_code,
  input  logic                        last_in_line,
  output llks_pkg::beat_t             beat
);
  import llks_pkg::*;

  // Fold case: 'A' and 'a' share their low five bits, one above the index
  always_comb begin
    beat.letter = is_letter(char_code);
    beat.bnd    = is_boundary(char_code);
    beat.idx    = LETTER_W'(char_code[LETTER_W-1:0] - 5'd1);
    beat.last   = last_in_line;
  end

endmodule

@@ rtl/llks_beat_queue.sv @@
// ---------------------------------------------------------------------------
// Log level keyword scanner: beat queue
// Two-entry queue that decouples the front end from the trie back end.
// ---------------------------------------------------------------------------
module llks_beat_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  llks_pkg::beat_t wr_beat,
  output logic            full,
  input  logic            rd_en,
  output llks_pkg::qstat_t rd_stat
);
  import llks_pkg::*;

  beat_t      q_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_beat;
    end
  end

  assign full          = (cnt_r == 2'd2);
  assign rd_stat.valid = (cnt_r != 2'd0);
  assign rd_stat.beat  = q_r[rd_ptr_r];

endmodule

@@ rtl/llks_back.sv @@
// ---------------------------------------------------------------------------
// Log level keyword scanner: back end
// Walks the keyword trie one beat a cycle unless a held verdict stalls a line end, and holds the line verdict.
// ---------------------------------------------------------------------------
module llks_back #(
  parameter int POS_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [llks_pkg::LIMIT_W-1:0] scan_limit,
  input  llks_pkg::qstat_t             q_stat,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [llks_pkg::LEVEL_W-1:0] level_code,
  output logic [llks_pkg::START_W-1:0] match_start
);
  import llks_pkg::*;
  `include "log_level_keyword_scanner_unit_macros.svh"

  localparam int CMP_W = (POS_BITS > START_W) ? POS_BITS : START_W;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] pos_nxt;
  logic                prev_bnd_r;
  logic                prev_bnd_nxt;
  logic [NODE_W-1:0]   node_r;
  logic [NODE_W-1:0]   node_nxt;
  logic [POS_BITS-1:0] cand_r;
  logic [POS_BITS-1:0] cand_nxt;
  logic                found_r;
  logic                found_nxt;
  level_t              found_level_r;
  level_t              found_level_nxt;
  logic [POS_BITS-1:0] found_start_r;
  logic [POS_BITS-1:0] found_start_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  level_t              out_level_r;
  logic [START_W-1:0]  out_start_r;
  level_t              res_level;
  logic [START_W-1:0]  res_start;
  logic                step;
  beat_t               bt;
  logic [CMP_W-1:0]    limit_ext;
  logic [CMP_W-1:0]    start_ext;

  assign bt        = q_stat.beat;
  assign limit_ext = CMP_W'(scan_limit);

  // Take a beat unless it closes a line while the result slot stays full
  assign step  = q_stat.valid && (!bt.last || !out_valid_r || pop);
  assign q_pop = step;

  // Trie step, boundary accept and line-end accept
  always_comb begin
    logic [NODE_W-1:0]   nd;
    logic                fnd;
    level_t              lvl;
    logic [POS_BITS-1:0] fst;
    logic [POS_BITS-1:0] cnd;
    logic [POS_BITS-1:0] nx;

    nd  = node_r;
    fnd = found_r;
    lvl = found_level_r;
    fst = found_start_r;
    cnd = cand_r;
    nx  = (pos_r == POS_MAX) ? POS_MAX : pos_r + 1'b1;

    if (node_r != '0) begin
      if (bt.letter) begin
        nd = trie_child(node_r, bt.idx);
      end else begin
        if (bt.bnd && !fnd && NODE_LEVEL[node_r] != LVL_NONE &&
            CMP_W'(pos_r) <= limit_ext) begin
          fnd = 1'b1;
          lvl = NODE_LEVEL[node_r];
          fst = cand_r;
        end
        nd = '0;
      end
    end else if (bt.letter && prev_bnd_r && !found_r) begin
      nd  = trie_child('0, bt.idx);
      cnd = pos_r;
    end

    // Close the line: the end of the line is a boundary too
    if (bt.last && nd != '0 && !fnd && NODE_LEVEL[nd] != LVL_NONE &&
        CMP_W'(nx) <= limit_ext) begin
      fnd = 1'b1;
      lvl = NODE_LEVEL[nd];
      fst = cnd;
    end

    res_level = fnd ? lvl : LVL_NONE;
    start_ext = fnd ? CMP_W'(fst) : '0;
    res_start = start_ext[START_W-1:0];

    pos_nxt         = pos_r;
    prev_bnd_nxt    = prev_bnd_r;
    node_nxt        = node_r;
    cand_nxt        = cand_r;
    found_nxt       = found_r;
    found_level_nxt = found_level_r;
    found_start_nxt = found_start_r;
    if (step) begin
      if (bt.last) begin
        pos_nxt         = '0;
        prev_bnd_nxt    = 1'b1;
        node_nxt        = '0;
        cand_nxt        = '0;
        found_nxt       = 1'b0;
        found_level_nxt = LVL_NONE;
        found_start_nxt = '0;
      end else begin
        pos_nxt         = nx;
        prev_bnd_nxt    = bt.bnd;
        node_nxt        = nd;
        cand_nxt        = cnd;
        found_nxt       = fnd;
        found_level_nxt = lvl;
        found_start_nxt = fst;
      end
    end

    // Hold the result until it is popped
    out_valid_nxt = out_valid_r;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (step && bt.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      prev_bnd_r    <= 1'b1;
      node_r        <= '0;
      cand_r        <= '0;
      found_r       <= 1'b0;
      found_level_r <= LVL_NONE;
      found_start_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      prev_bnd_r    <= prev_bnd_nxt;
      node_r        <= node_nxt;
      cand_r        <= cand_nxt;
      found_r       <= found_nxt;
      found_level_r <= found_level_nxt;
      found_start_r <= found_start_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (step && bt.last) begin
      out_level_r <= res_level;
      out_start_r <= res_start;
    end
  end

  assign empty       = !out_valid_r;
  assign level_code  = out_level_r;
  assign match_start = out_start_r;

  `LLKS_ASSERT_ALWAYS(a_node_range, clk, rst_n, node_r < NODE_W'(NODE_COUNT),
                      "trie node out of range")
  `LLKS_ASSERT_IMPLY(a_found_level, clk, rst_n, found_r, found_level_r != LVL_NONE,
                     "found flag set without a level")
  `LLKS_ASSERT_NEXT(a_line_clear, clk, rst_n, step && bt.last,
                    pos_r == '0 && node_r == '0 && !found_r && out_valid_r,
                    "line state not cleared after line end")
  `LLKS_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, step && bt.last, !out_valid_r || pop,
                     "result slot overwritten before pop")

endmodule
